// ----- rtl/csg_pkg.sv -----
package csg_pkg;

   // Grid geometry; SIDE must be a power of two so that wrap-around is free
   localparam int SIDE = 64;
   localparam int SIDE_BITS = $clog2(SIDE);
   localparam int CELLS = SIDE * SIDE;
   localparam int CELL_BITS = 2 * SIDE_BITS;
   localparam int ADDR_BITS = CELL_BITS + 1;
   localparam int DEPTH = 2 * CELLS;
   localparam int CNT_W = 13;

   // Scores are integers scaled by CELLS*4096*4096
   localparam int SCORE_W = 48;
   localparam int NBR_SHIFT = CELL_BITS + 12;
   localparam logic signed [SCORE_W-1:0] SCORE_ABSENT =
      -(SCORE_W'(CELLS) <<< 24);
   localparam logic signed [17:0] COOP_BENEFIT = 18'sd4096;

   // Request actions
   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_STEP = 2'd1;
   localparam logic [1:0] ACT_READ = 2'd2;

   // Register indexes
   localparam logic [2:0] REG_BENEFIT_FIRST = 3'd0;
   localparam logic [2:0] REG_BENEFIT_SECOND = 3'd1;
   localparam logic [2:0] REG_OWN_WEIGHT = 3'd2;
   localparam logic [2:0] REG_OTHER_WEIGHT = 3'd3;
   localparam logic [2:0] REG_PERSIST_FROM = 3'd4;
   localparam logic [2:0] REG_PERSIST_TILL = 3'd5;

   typedef logic [ADDR_BITS-1:0] addr_type;

   // Address of window position j (row-major 3x3, center is 4) around a cell
   function automatic addr_type nbr_addr(input addr_type a, input logic [3:0] j);
      logic [SIDE_BITS-1:0] y;
      logic [SIDE_BITS-1:0] x;
      logic [SIDE_BITS-1:0] dy;
      logic [SIDE_BITS-1:0] dx;
      y = a[CELL_BITS-1:SIDE_BITS];
      x = a[SIDE_BITS-1:0];
      case (j)
         4'd0, 4'd1, 4'd2: dy = {SIDE_BITS{1'b1}};
         4'd6, 4'd7, 4'd8: dy = SIDE_BITS'(1);
         default: dy = '0;
      endcase
      case (j)
         4'd0, 4'd3, 4'd6: dx = {SIDE_BITS{1'b1}};
         4'd2, 4'd5, 4'd8: dx = SIDE_BITS'(1);
         default: dx = '0;
      endcase
      return {a[ADDR_BITS-1], y + dy, x + dx};
   endfunction

endpackage

// ----- rtl/csg_ram.sv -----
module csg_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write one entry, read one entry with registered data
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/csg_mul.sv -----
module csg_mul (
   input  logic               clock,
   input  logic signed [31:0] a,
   input  logic signed [17:0] b,
   output logic signed [49:0] p
);

   logic signed [49:0] p_ff;

   // Register the product
   always_ff @(posedge clock) begin
      p_ff <= a * b;
   end

   assign p = p_ff;

endmodule

// ----- rtl/coupled_spatial_game_generation.sv -----
// Channel   | Ports                                   | Handshake
// request   | req_action/grid_select/cell_index/...   | start && !busy
// response  | rsp_read_strategy ... rsp_generation    | rsp_valid, one cycle
// config    | csr_psel/penable/pwrite/paddr/pwdata    | APB, pready tied high
//
// After reset a clearing pass over every entry of both grids runs with busy high.
// A write runs read, update, fetch and response states; a read runs fetch
// and response. A step runs self, score, update, copy and finish passes:
// each cell reads its nine window entries one by one through the single
// read port, and every score goes through the one shared multiplier.
// The response is shown for one cycle and cannot be stalled.
module coupled_spatial_game_generation (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic        req_grid_select,
   input  logic [11:0] req_cell_index,
   input  logic        req_cell_strategy,
   output logic        rsp_valid,
   output logic        rsp_read_strategy,
   output logic        rsp_read_persistent,
   output logic [12:0] rsp_coop_count_first,
   output logic [12:0] rsp_coop_count_second,
   output logic [12:0] rsp_persist_count_first,
   output logic [12:0] rsp_persist_count_second,
   output logic [15:0] rsp_generation,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   import csg_pkg::*;

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE = 4'd1;
   localparam logic [3:0] ST_WR_RD = 4'd2;
   localparam logic [3:0] ST_WR_UPD = 4'd3;
   localparam logic [3:0] ST_SELF = 4'd4;
   localparam logic [3:0] ST_SCORE = 4'd5;
   localparam logic [3:0] ST_UPDATE = 4'd6;
   localparam logic [3:0] ST_COPY = 4'd7;
   localparam logic [3:0] ST_FINISH = 4'd8;
   localparam logic [3:0] ST_FETCH = 4'd9;
   localparam logic [3:0] ST_RESP = 4'd10;

   // Configuration registers
   logic [15:0] benefit_first_ff;
   logic [15:0] benefit_second_ff;
   logic signed [15:0] own_weight_ff;
   logic signed [15:0] other_weight_ff;
   logic signed [16:0] persist_from_ff;
   logic [15:0] persist_till_ff;
   logic cfg_wr;

   // Control and status
   logic [3:0] state_ff, state_in;
   logic [ADDR_BITS:0] cnt_ff, cnt_in;
   logic [3:0] step_ff, step_in;
   logic [1:0] action_ff, action_in;
   logic valid_ff, valid_in;
   addr_type key_ff, key_in;
   logic wstrat_ff, wstrat_in;
   logic [CNT_W-1:0] coop_ff [2];
   logic [CNT_W-1:0] coop_in [2];
   logic [CNT_W-1:0] pers_ff [2];
   logic [CNT_W-1:0] pers_in [2];
   logic [CNT_W-1:0] cacc_ff [2];
   logic [CNT_W-1:0] cacc_in [2];
   logic [CNT_W-1:0] pacc_ff [2];
   logic [CNT_W-1:0] pacc_in [2];
   logic [15:0] gen_ff, gen_in;

   // Per-generation working registers
   logic signed [31:0] self_ff [2];
   logic signed [31:0] self_in [2];
   logic [3:0] nsum_ff, nsum_in;
   logic center_ff, center_in;
   logic signed [SCORE_W-1:0] best_ff [2];
   logic signed [SCORE_W-1:0] best_in [2];

   // Response registers
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_strat_ff, rsp_strat_in;
   logic rsp_pers_ff, rsp_pers_in;

   // Memory ports
   addr_type rd_addr;
   logic strat_we, strat_wd, strat_rd;
   addr_type strat_wa;
   logic pers_we, pers_wd, pers_rd;
   addr_type pers_wa;
   logic next_we, next_wd, next_rd;
   logic score_we;
   logic signed [SCORE_W-1:0] score_rd;
   addr_type cell_addr;
   addr_type copy_addr;

   // Shared multiplier
   logic signed [31:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [49:0] mul_p;
   logic signed [SCORE_W-1:0] product;

   logic track;
   logic cell_last;
   logic [3:0] j_prev;
   logic cur;
   logic switch_c;

   csg_mul u_mul (.clock(clock), .a(mul_a), .b(mul_b), .p(mul_p));
   assign product = mul_p[SCORE_W-1:0];

   csg_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_strat (
      .clock(clock), .we(strat_we), .waddr(strat_wa), .wdata(strat_wd),
      .raddr(rd_addr), .rdata(strat_rd));
   csg_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_pers (
      .clock(clock), .we(pers_we), .waddr(pers_wa), .wdata(pers_wd),
      .raddr(rd_addr), .rdata(pers_rd));
   csg_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_next (
      .clock(clock), .we(next_we), .waddr(cell_addr), .wdata(next_wd),
      .raddr(rd_addr), .rdata(next_rd));
   csg_ram #(.WIDTH(SCORE_W), .DEPTH(DEPTH)) u_score (
      .clock(clock), .we(score_we), .waddr(cell_addr), .wdata(product),
      .raddr(rd_addr), .rdata(score_rd));

   // Configuration port
   assign csr_pready = 1'b1;
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         benefit_first_ff <= 16'd4096;
         benefit_second_ff <= 16'd4096;
         own_weight_ff <= '0;
         other_weight_ff <= '0;
         persist_from_ff <= '1;
         persist_till_ff <= '0;
      end else if (cfg_wr) begin
         case (csr_paddr[4:2])
            REG_BENEFIT_FIRST: benefit_first_ff <= csr_pwdata[15:0];
            REG_BENEFIT_SECOND: benefit_second_ff <= csr_pwdata[15:0];
            REG_OWN_WEIGHT: own_weight_ff <= csr_pwdata[15:0];
            REG_OTHER_WEIGHT: other_weight_ff <= csr_pwdata[15:0];
            REG_PERSIST_FROM: persist_from_ff <= csr_pwdata[16:0];
            REG_PERSIST_TILL: persist_till_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         REG_BENEFIT_FIRST: csr_prdata = {16'd0, benefit_first_ff};
         REG_BENEFIT_SECOND: csr_prdata = {16'd0, benefit_second_ff};
         REG_OWN_WEIGHT: csr_prdata = 32'(own_weight_ff);
         REG_OTHER_WEIGHT: csr_prdata = 32'(other_weight_ff);
         REG_PERSIST_FROM: csr_prdata = 32'(persist_from_ff);
         REG_PERSIST_TILL: csr_prdata = {16'd0, persist_till_ff};
         default: csr_prdata = '0;
      endcase
   end

   // Switches clear persistence only inside the open window
   assign track = !persist_from_ff[16] && (gen_ff > persist_from_ff[15:0]) &&
                  (gen_ff < persist_till_ff);

   assign cell_addr = cnt_ff[ADDR_BITS-1:0];
   assign copy_addr = cnt_ff[ADDR_BITS-1:0] - ADDR_BITS'(1);
   assign cell_last = (cell_addr == ADDR_BITS'(DEPTH - 1));
   assign j_prev = step_ff - 4'd1;
   assign cur = center_ff;
   assign switch_c = best_ff[cur] < best_ff[!cur];

   // Read address: window walk, copy sweep or the addressed cell
   always_comb begin
      case (state_ff)
         ST_SCORE, ST_UPDATE: rd_addr = nbr_addr(cell_addr, step_ff);
         ST_COPY: rd_addr = cell_addr;
         default: rd_addr = key_ff;
      endcase
   end

   // Multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_SELF) begin
         case (step_ff)
            4'd0: begin
               mul_a = 32'(own_weight_ff);
               mul_b = 18'(coop_ff[0]);
            end
            4'd1: begin
               mul_a = 32'(other_weight_ff);
               mul_b = 18'(coop_ff[1]);
            end
            4'd2: begin
               mul_a = 32'(own_weight_ff);
               mul_b = 18'(coop_ff[1]);
            end
            4'd3: begin
               mul_a = 32'(other_weight_ff);
               mul_b = 18'(coop_ff[0]);
            end
            default: ;
         endcase
      end else begin
         mul_a = (32'(nsum_ff) <<< NBR_SHIFT) + self_ff[cell_addr[ADDR_BITS-1]];
         if (center_ff) begin
            mul_b = COOP_BENEFIT;
         end else if (cell_addr[ADDR_BITS-1]) begin
            mul_b = 18'(benefit_second_ff);
         end else begin
            mul_b = 18'(benefit_first_ff);
         end
      end
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      step_in = step_ff;
      action_in = action_ff;
      valid_in = valid_ff;
      key_in = key_ff;
      wstrat_in = wstrat_ff;
      coop_in = coop_ff;
      pers_in = pers_ff;
      cacc_in = cacc_ff;
      pacc_in = pacc_ff;
      gen_in = gen_ff;
      self_in = self_ff;
      nsum_in = nsum_ff;
      center_in = center_ff;
      best_in = best_ff;
      rsp_valid_in = 1'b0;
      rsp_strat_in = rsp_strat_ff;
      rsp_pers_in = rsp_pers_ff;
      strat_we = 1'b0;
      strat_wa = key_ff;
      strat_wd = wstrat_ff;
      pers_we = 1'b0;
      pers_wa = key_ff;
      pers_wd = 1'b1;
      next_we = 1'b0;
      next_wd = 1'b0;
      score_we = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            strat_we = 1'b1;
            strat_wa = cell_addr;
            strat_wd = 1'b0;
            pers_we = 1'b1;
            pers_wa = cell_addr;
            cnt_in = cnt_ff + 1'b1;
            if (cell_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               action_in = req_action;
               valid_in = ({1'b0, req_cell_index} < 13'(CELLS));
               key_in = {req_grid_select, req_cell_index[CELL_BITS-1:0]};
               wstrat_in = req_cell_strategy;
               step_in = '0;
               case (req_action)
                  ACT_WRITE: state_in = ST_WR_RD;
                  ACT_STEP: state_in = ST_SELF;
                  default: state_in = ST_FETCH;
               endcase
            end
         end
         ST_WR_RD: begin
            state_in = ST_WR_UPD;
         end
         ST_WR_UPD: begin
            gen_in = 16'd1;
            if (valid_ff) begin
               strat_we = 1'b1;
               coop_in[key_ff[ADDR_BITS-1]] = coop_ff[key_ff[ADDR_BITS-1]] -
                  CNT_W'(strat_rd) + CNT_W'(wstrat_ff);
               if (!pers_rd) begin
                  pers_we = 1'b1;
                  pers_in[key_ff[ADDR_BITS-1]] = pers_ff[key_ff[ADDR_BITS-1]] + 1'b1;
               end
            end
            state_in = ST_FETCH;
         end
         ST_SELF: begin
            // Four products: own and other weight terms for each grid
            step_in = step_ff + 4'd1;
            case (step_ff)
               4'd0: begin
                  self_in[0] = '0;
                  self_in[1] = '0;
               end
               4'd1, 4'd2: self_in[0] = self_ff[0] + 32'(product);
               default: self_in[1] = self_ff[1] + 32'(product);
            endcase
            if (step_ff == 4'd4) begin
               state_in = ST_SCORE;
               step_in = '0;
               cnt_in = '0;
            end
         end
         ST_SCORE: begin
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd0) begin
               nsum_in = '0;
            end
            if (step_ff >= 4'd1 && step_ff <= 4'd9) begin
               if (j_prev == 4'd4) begin
                  center_in = strat_rd;
               end else begin
                  nsum_in = nsum_ff + 4'(strat_rd);
               end
            end
            if (step_ff == 4'd11) begin
               score_we = 1'b1;
               step_in = '0;
               cnt_in = cnt_ff + 1'b1;
               if (cell_last) begin
                  state_in = ST_UPDATE;
                  cnt_in = '0;
               end
            end
         end
         ST_UPDATE: begin
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd0) begin
               best_in[0] = SCORE_ABSENT;
               best_in[1] = SCORE_ABSENT;
            end
            if (step_ff >= 4'd1 && step_ff <= 4'd9) begin
               if (score_rd > best_ff[strat_rd]) begin
                  best_in[strat_rd] = score_rd;
               end
               if (j_prev == 4'd4) begin
                  center_in = strat_rd;
               end
            end
            if (step_ff == 4'd10) begin
               next_we = 1'b1;
               next_wd = cur ^ switch_c;
               if (switch_c && track) begin
                  pers_we = 1'b1;
                  pers_wa = cell_addr;
                  pers_wd = 1'b0;
               end
               step_in = '0;
               cnt_in = cnt_ff + 1'b1;
               if (cell_last) begin
                  state_in = ST_COPY;
                  cnt_in = '0;
                  cacc_in[0] = '0;
                  cacc_in[1] = '0;
                  pacc_in[0] = '0;
                  pacc_in[1] = '0;
               end
            end
         end
         ST_COPY: begin
            // Move next strategies in and recount both grids
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff != '0) begin
               strat_we = 1'b1;
               strat_wa = copy_addr;
               strat_wd = next_rd;
               cacc_in[copy_addr[ADDR_BITS-1]] =
                  cacc_ff[copy_addr[ADDR_BITS-1]] + CNT_W'(next_rd);
               pacc_in[copy_addr[ADDR_BITS-1]] =
                  pacc_ff[copy_addr[ADDR_BITS-1]] + CNT_W'(pers_rd);
            end
            if (cnt_ff == (ADDR_BITS+1)'(DEPTH)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            coop_in = cacc_ff;
            pers_in = pacc_ff;
            if (gen_ff != 16'hFFFF) begin
               gen_in = gen_ff + 16'd1;
            end
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid_in = 1'b1;
            rsp_strat_in = valid_ff && strat_rd;
            rsp_pers_in = valid_ff && pers_rd;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff <= '0;
         step_ff <= '0;
         coop_ff[0] <= '0;
         coop_ff[1] <= '0;
         pers_ff[0] <= CNT_W'(CELLS);
         pers_ff[1] <= CNT_W'(CELLS);
         gen_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         step_ff <= step_in;
         coop_ff <= coop_in;
         pers_ff <= pers_in;
         gen_ff <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      action_ff <= action_in;
      valid_ff <= valid_in;
      key_ff <= key_in;
      wstrat_ff <= wstrat_in;
      cacc_ff <= cacc_in;
      pacc_ff <= pacc_in;
      self_ff <= self_in;
      nsum_ff <= nsum_in;
      center_ff <= center_in;
      best_ff <= best_in;
      rsp_strat_ff <= rsp_strat_in;
      rsp_pers_ff <= rsp_pers_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_read_strategy = rsp_strat_ff;
   assign rsp_read_persistent = rsp_pers_ff;
   assign rsp_coop_count_first = coop_ff[0];
   assign rsp_coop_count_second = coop_ff[1];
   assign rsp_persist_count_first = pers_ff[0];
   assign rsp_persist_count_second = pers_ff[1];
   assign rsp_generation = gen_ff;

   // A response only follows the response state
   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_RESP))
      else $error("response without response state");

   // An accepted request makes the block busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request accepted but block not busy");

   // Counts never exceed the grid size
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      coop_ff[0] <= CNT_W'(CELLS) && coop_ff[1] <= CNT_W'(CELLS) &&
      pers_ff[0] <= CNT_W'(CELLS) && pers_ff[1] <= CNT_W'(CELLS))
      else $error("cell count out of range");

   // A step action leaves through the copy sweep
   a_finish_after_copy: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH |-> $past(state_ff == ST_COPY) && action_ff == ACT_STEP)
      else $error("finish without copy sweep");

endmodule
